>>> hw/rtl/vsp_pkg.sv
// vsp_pkg: shared types, constants and saturation helpers for the vertex
// screen projection block. No dependencies; every other file imports it.
package vsp_pkg;

  // Fixed field widths.
  localparam int CW    = 32;  // coordinate width
  localparam int FOCW  = 31;  // focal_scale
  localparam int OSW   = 32;  // ortho_scale
  localparam int ASPW  = 31;  // aspect_ratio
  localparam int HALFW = 29;  // half_width / half_height
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int FRAC_BITS_DEF = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int DIG           = 16;  // multiplier digit width
  localparam int PW            = 64;  // rounded product width
  localparam int WW            = 66;  // width of the final sums

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OSCALE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ASPECT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HWIDTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HHEIGHT = 3'd5;

  localparam logic signed [WW-1:0] C_MAX = signed'(WW'({1'b0, {(CW-1){1'b1}}}));
  localparam logic signed [WW-1:0] C_MIN = -C_MAX - WW'(1);

  typedef struct packed {
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    logic signed [CW-1:0] vz;
  } vsp_in_t;

  typedef struct packed {
    logic signed [CW-1:0] screen_x;
    logic signed [CW-1:0] screen_y;
    logic signed [CW-1:0] depth_out;
    logic                 zero_depth;
    logic                 saturated;
  } vsp_out_t;

  typedef struct packed {
    logic                    mode;
    logic [FOCW-1:0]         focal;
    logic signed [OSW-1:0]   oscale;
    logic [ASPW-1:0]         aspect;
    logic [HALFW-1:0]        half_width;
    logic [HALFW-1:0]        half_height;
  } vsp_cfg_t;

  // Classified request: flags plus sign/magnitude of each coordinate.
  typedef struct packed {
    logic                 persp;
    logic                 zero;
    logic                 square;
    logic                 x_neg;
    logic                 y_neg;
    logic                 z_neg;
    logic [CW-1:0]        x_mag;
    logic [CW-1:0]        y_mag;
    logic [CW-1:0]        z_mag;
    logic signed [CW-1:0] vy;
  } vsp_ent_t;

  typedef struct packed {
    logic     valid;
    vsp_ent_t ent;
  } vsp_tok_t;

  function automatic logic [CW-1:0] clamp_coord(input logic signed [WW-1:0] v);
    if (v > C_MAX) return C_MAX[CW-1:0];
    else if (v < C_MIN) return C_MIN[CW-1:0];
    else return v[CW-1:0];
  endfunction

  function automatic logic out_of_range(input logic signed [WW-1:0] v);
    return (v > C_MAX) || (v < C_MIN);
  endfunction

endpackage

>>> hw/rtl/vertex_screen_projection.sv
// vertex_screen_projection: top level with the configuration registers.
// Depends on vsp_pkg, vsp_front, vsp_queue, vsp_back.
//
// Projects one camera-space vertex (vx across, vy depth, vz up, signed
// fixed point) to a screen position and depth, perspective or orthographic.
// Input channel in_valid/in_stall/in_data carries one vertex per request;
// output channel out_valid/out_stall/out_data carries one result per vertex,
// in order. A request is taken at an edge with valid high and stall low.
// Configuration: cfg_we with cfg_idx and cfg_wdata writes one register in a
// cycle; write only while no vertex is in flight.
// Throughput: one vertex per clock while no result waits under out_stall. The
// divider for the perspective factor computes one quotient bit per stage.
// A short queue parts the classifying front from the execution pipeline.
// Reset (rst_n low, synchronous) empties all stages and restores perspective
// mode, unit ortho scale and aspect, and zero focal length and screen center.
// While a result waits under out_stall it holds and the execution pipeline
// freezes; the front keeps taking requests until the queue fills.
module vertex_screen_projection #(
  parameter int FRAC_BITS = vsp_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  vsp_pkg::vsp_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output vsp_pkg::vsp_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [vsp_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [vsp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import vsp_pkg::*;

  localparam logic [4:0] FRAC_SH = 5'(FRAC_BITS);

  vsp_cfg_t cfg_r;

  // Register file; bits above each register's width are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= 1'b1;
      cfg_r.focal       <= '0;
      cfg_r.oscale      <= signed'(OSW'(1) << FRAC_BITS);
      cfg_r.aspect      <= ASPW'(1) << FRAC_BITS;
      cfg_r.half_width  <= '0;
      cfg_r.half_height <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MODE:    cfg_r.mode        <= cfg_wdata[0];
        CFG_FOCAL:   cfg_r.focal       <= cfg_wdata[FOCW-1:0];
        CFG_OSCALE:  cfg_r.oscale      <= signed'(cfg_wdata[OSW-1:0]);
        CFG_ASPECT:  cfg_r.aspect      <= cfg_wdata[ASPW-1:0];
        CFG_HWIDTH:  cfg_r.half_width  <= cfg_wdata[HALFW-1:0];
        CFG_HHEIGHT: cfg_r.half_height <= cfg_wdata[HALFW-1:0];
        default:     cfg_r             <= cfg_r;
      endcase
    end
  end

  logic     q_push, q_full, q_pop, q_nonempty;
  vsp_ent_t q_wdata, q_rdata;

  // Front: stage and classify each request.
  vsp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .frac_sh  (FRAC_SH)
  );

  vsp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .nonempty (q_nonempty)
  );

  // Back: divide, multiply, offset and clamp.
  vsp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_nonempty (q_nonempty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

>>> hw/rtl/vsp_front.sv
// vsp_front: input staging register and request classification.
// Depends on vsp_pkg.
module vsp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  vsp_pkg::vsp_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  vsp_pkg::vsp_in_t  in_data,
  input  logic              q_full,
  output logic              q_push,
  output vsp_pkg::vsp_ent_t q_wdata,
  input  logic [4:0]        frac_sh
);
  import vsp_pkg::*;

  logic     valid_r;
  vsp_ent_t ent_r;
  vsp_ent_t ent_nxt;
  logic     accept;

  assign q_push   = valid_r && !q_full;
  assign in_stall = valid_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_wdata  = ent_r;

  always_comb begin
    ent_nxt.persp  = cfg.mode;
    ent_nxt.zero   = cfg.mode && (in_data.vy == '0);
    ent_nxt.square = (cfg.aspect == (ASPW'(1) << frac_sh));
    ent_nxt.x_neg  = in_data.vx[CW-1];
    ent_nxt.y_neg  = in_data.vy[CW-1];
    ent_nxt.z_neg  = in_data.vz[CW-1];
    ent_nxt.x_mag  = in_data.vx[CW-1] ? CW'(-in_data.vx) : CW'(in_data.vx);
    ent_nxt.y_mag  = in_data.vy[CW-1] ? CW'(-in_data.vy) : CW'(in_data.vy);
    ent_nxt.z_mag  = in_data.vz[CW-1] ? CW'(-in_data.vz) : CW'(in_data.vz);
    ent_nxt.vy     = in_data.vy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
      ent_r   <= ent_nxt;
    end else if (q_push) begin
      valid_r <= 1'b0;
    end
  end

endmodule

>>> hw/rtl/vsp_queue.sv
// vsp_queue: small FIFO of classified requests between front and back.
// Depends on vsp_pkg.
module vsp_queue #(
  parameter int DEPTH = vsp_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  vsp_pkg::vsp_ent_t wdata,
  output logic              full,
  input  logic              pop,
  output vsp_pkg::vsp_ent_t rdata,
  output logic              nonempty
);
  import vsp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  vsp_ent_t          mem [DEPTH];
  logic [AW-1:0]     wr_r, rd_r;
  logic [AW:0]       cnt_r;

  assign full     = (cnt_r == (AW+1)'(DEPTH));
  assign nonempty = (cnt_r != '0);
  assign rdata    = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == AW'(DEPTH-1)) ? '0 : wr_r + AW'(1);
      if (pop)  rd_r <= (rd_r == AW'(DEPTH-1)) ? '0 : rd_r + AW'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (AW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (AW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

>>> hw/rtl/vsp_div.sv
// vsp_div: pipelined restoring divider, one quotient bit per stage.
// Depends on vsp_pkg.
module vsp_div #(
  parameter int NW = 47,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);
  import vsp_pkg::*;

  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] quo_r [NW];
  logic [NW-1:0] num_r [NW];
  logic [DW-1:0] den_r [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stg
    logic [DW-1:0] rem_in, den_in;
    logic [NW-1:0] num_in, quo_in;
    logic [DW:0]   trial, diff;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign num_in = num_r[i-1];
      assign den_in = den_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    assign trial = {rem_in, num_in[NW-1-i]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[i] <= num_in;
        den_r[i] <= den_in;
        if (!diff[DW]) begin
          rem_r[i] <= diff[DW-1:0];
          quo_r[i] <= quo_in | (NW'(1) << (NW-1-i));
        end else begin
          rem_r[i] <= trial[DW-1:0];
          quo_r[i] <= quo_in;
        end
      end
    end
  end

  assign quo = quo_r[NW-1];

endmodule

>>> hw/rtl/vsp_mulq.sv
// vsp_mulq: digit-pipelined fixed-point multiply of sign/magnitude operands,
// rounded toward minus infinity and limited to 2^62. Depends on vsp_pkg.
module vsp_mulq #(
  parameter int AW   = 32,
  parameter int BW   = 47,
  parameter int FRAC = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [AW-1:0]                 a,
  input  logic [BW-1:0]                 b,
  input  logic                          neg,
  output logic signed [vsp_pkg::PW-1:0] res
);
  import vsp_pkg::*;

  localparam int NB  = (BW + DIG - 1) / DIG;
  localparam int FW  = AW + BW;
  localparam int QWD = FW - FRAC;
  localparam int EW  = (QWD > 64) ? QWD : 64;
  localparam logic [EW-1:0] LIM = EW'(1) << 62;

  logic [AW-1:0]     a_r   [NB];
  logic [NB*DIG-1:0] b_r   [NB];
  logic              neg_r [NB];
  logic [FW-1:0]     acc_r [NB];

  for (genvar j = 0; j < NB; j++) begin : g_dig
    logic [AW-1:0]     a_in;
    logic [NB*DIG-1:0] b_in;
    logic              neg_in;
    logic [FW-1:0]     acc_in;
    logic [AW+DIG-1:0] pp;

    if (j == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = (NB*DIG)'(b);
      assign neg_in = neg;
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_r[j-1];
      assign b_in   = b_r[j-1];
      assign neg_in = neg_r[j-1];
      assign acc_in = acc_r[j-1];
    end

    assign pp = (AW+DIG)'(a_in) * (AW+DIG)'(b_in[j*DIG +: DIG]);

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[j]   <= a_in;
        b_r[j]   <= b_in;
        neg_r[j] <= neg_in;
        acc_r[j] <= acc_in + (FW'(pp) << (DIG*j));
      end
    end
  end

  logic [FW-1:0] p;
  logic [EW-1:0] q_e;
  logic          rem;
  logic [62:0]   q_c, q_i, q_f;

  // Round the magnitude down, then bump it for a negative inexact result.
  always_comb begin
    p   = acc_r[NB-1];
    q_e = EW'(p >> FRAC);
    rem = |p[FRAC-1:0];
    q_c = (q_e > LIM) ? LIM[62:0] : q_e[62:0];
    q_i = q_c + 63'(neg_r[NB-1] && rem);
    q_f = (EW'(q_i) > LIM) ? LIM[62:0] : q_i;
  end

  always_ff @(posedge clk) begin
    if (en) res <= neg_r[NB-1] ? -signed'(PW'(q_f)) : signed'(PW'(q_f));
  end

endmodule

>>> hw/rtl/vsp_back.sv
// vsp_back: execution pipeline (divider, two multiply phases, sum and clamp)
// with the output register. Depends on vsp_pkg, vsp_div, vsp_mulq.
module vsp_back #(
  parameter int FRAC_BITS = vsp_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  vsp_pkg::vsp_cfg_t cfg,
  input  logic              q_nonempty,
  input  vsp_pkg::vsp_ent_t q_rdata,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output vsp_pkg::vsp_out_t out_data
);
  import vsp_pkg::*;

  localparam int QW  = FOCW + FRAC_BITS;
  localparam int BWB = (QW > OSW) ? QW : OSW;
  localparam int LB  = (BWB + DIG - 1) / DIG + 1;
  localparam int LC  = (ASPW + DIG - 1) / DIG + 1;

  typedef struct packed {
    vsp_tok_t             tok;
    logic signed [PW-1:0] p1;
    logic signed [PW-1:0] p2;
    logic signed [PW-1:0] p3;
  } vsp_mid_t;

  logic     out_valid_r;
  vsp_out_t out_data_r;
  logic     adv;

  // Whole pipeline holds while a finished result waits.
  assign adv   = !(out_valid_r && out_stall);
  assign q_pop = adv && q_nonempty;

  // Entry stage.
  vsp_tok_t s0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.valid <= 1'b0;
    end else if (adv) begin
      s0_r.valid <= q_nonempty;
      s0_r.ent   <= q_rdata;
    end
  end

  // Perspective factor k = (focal << FRAC) / |vy|.
  logic [QW-1:0] quo;
  vsp_div #(.NW(QW), .DW(CW)) u_div (
    .clk (clk),
    .en  (adv),
    .num ({cfg.focal, {FRAC_BITS{1'b0}}}),
    .den (s0_r.ent.y_mag),
    .quo (quo)
  );

  vsp_tok_t d_r [QW];
  for (genvar i = 0; i < QW; i++) begin : g_dly_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_r[i].valid <= 1'b0;
      end else if (adv) begin
        d_r[i] <= (i == 0) ? s0_r : d_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  // First multiply phase: x, z and vy against k or the ortho scale.
  vsp_tok_t       tb;
  logic [BWB-1:0] b_op;
  logic           s_neg;
  logic [OSW-1:0] os_mag;
  assign tb     = d_r[QW-1];
  assign os_mag = cfg.oscale[OSW-1] ? OSW'(-cfg.oscale) : OSW'(cfg.oscale);
  assign b_op   = tb.ent.persp ? BWB'(quo) : BWB'(os_mag);
  assign s_neg  = tb.ent.persp ? tb.ent.y_neg : cfg.oscale[OSW-1];

  logic signed [PW-1:0] p1, p2, p3, p4;

  vsp_mulq #(.AW(CW), .BW(BWB), .FRAC(FRAC_BITS)) u_mul_x (
    .clk(clk), .en(adv), .a(tb.ent.x_mag), .b(b_op),
    .neg(tb.ent.x_neg ^ s_neg), .res(p1)
  );
  vsp_mulq #(.AW(CW), .BW(BWB), .FRAC(FRAC_BITS)) u_mul_z (
    .clk(clk), .en(adv), .a(tb.ent.z_mag), .b(b_op),
    .neg(tb.ent.z_neg ^ s_neg), .res(p2)
  );
  vsp_mulq #(.AW(CW), .BW(BWB), .FRAC(FRAC_BITS)) u_mul_y (
    .clk(clk), .en(adv), .a(tb.ent.y_mag), .b(b_op),
    .neg(tb.ent.y_neg ^ s_neg), .res(p3)
  );

  vsp_tok_t e_r [LB];
  for (genvar i = 0; i < LB; i++) begin : g_dly_b
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        e_r[i].valid <= 1'b0;
      end else if (adv) begin
        e_r[i] <= (i == 0) ? tb : e_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  // Second multiply phase: -(z*scale) * aspect for the non-square ortho form.
  logic [62:0] t_mag;
  logic        t_neg;
  assign t_mag = p2[PW-1] ? 63'(-p2) : p2[62:0];
  assign t_neg = !p2[PW-1] && (p2 != '0);

  vsp_mulq #(.AW(63), .BW(ASPW), .FRAC(FRAC_BITS)) u_mul_asp (
    .clk(clk), .en(adv), .a(t_mag), .b(cfg.aspect), .neg(t_neg), .res(p4)
  );

  vsp_mid_t mc;
  assign mc.tok = e_r[LB-1];
  assign mc.p1  = p1;
  assign mc.p2  = p2;
  assign mc.p3  = p3;

  vsp_mid_t f_r [LC];
  for (genvar i = 0; i < LC; i++) begin : g_dly_c
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        f_r[i].tok.valid <= 1'b0;
      end else if (adv) begin
        f_r[i] <= (i == 0) ? mc : f_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  // Offset, clamp and pick the result.
  vsp_mid_t             fm;
  logic                 plain_y;
  logic signed [WW-1:0] hw_w, hh_w, sx_w, sy_w, d_w;
  vsp_out_t             res_nxt;

  always_comb begin
    fm      = f_r[LC-1];
    plain_y = fm.tok.ent.persp || fm.tok.ent.square;
    hw_w    = signed'(WW'(cfg.half_width));
    hh_w    = signed'(WW'(cfg.half_height));
    sx_w    = WW'(fm.p1) + hw_w;
    sy_w    = plain_y ? hh_w - WW'(fm.p2) : WW'(p4) + hh_w;
    d_w     = plain_y ? WW'(fm.tok.ent.vy) : WW'(fm.p3);
    if (fm.tok.ent.zero) begin
      res_nxt.screen_x   = C_MAX[CW-1:0];
      res_nxt.screen_y   = C_MAX[CW-1:0];
      res_nxt.depth_out  = '0;
      res_nxt.zero_depth = 1'b1;
      res_nxt.saturated  = 1'b1;
    end else begin
      res_nxt.screen_x   = clamp_coord(sx_w);
      res_nxt.screen_y   = clamp_coord(sy_w);
      res_nxt.depth_out  = clamp_coord(d_w);
      res_nxt.zero_depth = 1'b0;
      res_nxt.saturated  = out_of_range(sx_w) || out_of_range(sy_w) ||
                           out_of_range(d_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fm.tok.valid;
      out_data_r  <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/vsp_checker.sv
// vsp_assert: port-level assertions for vertex_screen_projection, bound
// to the top level. Depends on vsp_pkg.
module vsp_assert (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input vsp_pkg::vsp_out_t out_data
);
  import vsp_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Zero depth always reports saturation.
  a_zero_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_depth |-> out_data.saturated)
    else $error("zero depth without saturation flag");

  // Zero depth drives the fixed screen corner and a zero depth.
  a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_depth |->
      out_data.depth_out == '0 && out_data.screen_x == C_MAX[CW-1:0] &&
      out_data.screen_y == C_MAX[CW-1:0])
    else $error("zero depth result has wrong values");

  // Right after reset the block is empty and ready.
  a_reset_idle: assert property (@(posedge clk)
    !$past(rst_n) |-> !in_stall && !out_valid)
    else $error("block not idle after reset");

endmodule

bind vertex_screen_projection vsp_assert u_vsp_assert (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> bench/vsp_checker.sv
// vsp_checker: watches the vertex, result and configuration ports of the
// projection block, predicts each screen result and compares it in order.
// Depends on vsp_pkg for the payload types and register indexes.
`timescale 1ns / 100ps

module vsp_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  vsp_pkg::vsp_in_t               in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  vsp_pkg::vsp_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [vsp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [vsp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             pending,
  output int                             results_seen
);
  import vsp_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  typedef logic signed [127:0] wide_t;

  localparam wide_t PROD_LIM  = wide_t'(1) <<< 62;
  localparam wide_t COORD_TOP = (wide_t'(1) <<< (CW - 1)) - 1;
  localparam wide_t COORD_BOT = -(wide_t'(1) <<< (CW - 1));

  vsp_cfg_t proj_cfg;
  vsp_out_t screen_q[$];
  int       mismatches;

  // Exact product, floored by the fraction bits, magnitude limited to 2^62.
  function automatic wide_t fixed_mul(input wide_t a, input wide_t b);
    wide_t p;
    p = (a * b) >>> FRAC;
    if (p > PROD_LIM) p = PROD_LIM;
    if (p < -PROD_LIM) p = -PROD_LIM;
    return p;
  endfunction

  function automatic logic [CW-1:0] fit_coord(input wide_t v, inout logic sat);
    if (v > COORD_TOP) begin
      sat = 1'b1;
      return COORD_TOP[CW-1:0];
    end
    if (v < COORD_BOT) begin
      sat = 1'b1;
      return COORD_BOT[CW-1:0];
    end
    return v[CW-1:0];
  endfunction

  function automatic vsp_out_t project_vertex(input vsp_cfg_t c, input vsp_in_t v);
    vsp_out_t    r;
    wide_t       x, y, z, hw, hh, sx, sy, d, s, t, k;
    logic [63:0] uy, uk;
    logic        sat;
    x   = wide_t'(v.vx);
    y   = wide_t'(v.vy);
    z   = wide_t'(v.vz);
    hw  = wide_t'({1'b0, c.half_width});
    hh  = wide_t'({1'b0, c.half_height});
    sat = 1'b0;
    r   = '0;
    if (c.mode) begin
      if (y == 0) begin
        // zero depth: flag it and pin the position high
        r.screen_x   = COORD_TOP[CW-1:0];
        r.screen_y   = COORD_TOP[CW-1:0];
        r.depth_out  = '0;
        r.zero_depth = 1'b1;
        r.saturated  = 1'b1;
        return r;
      end
      uy = (y < 0) ? 64'(-y) : 64'(y);
      uk = (64'(c.focal) << FRAC) / uy;
      k  = wide_t'({1'b0, uk});
      if (y < 0) k = -k;
      sx = hw + fixed_mul(x, k);
      sy = hh - fixed_mul(z, k);
      d  = y;
    end else begin
      s  = wide_t'(c.oscale);
      sx = fixed_mul(s, x) + hw;
      if (c.aspect == ASPW'(1 << FRAC)) begin
        sy = hh - fixed_mul(z, s);
        d  = y;
      end else begin
        t  = fixed_mul(z, s);
        sy = fixed_mul(-t, wide_t'({1'b0, c.aspect})) + hh;
        d  = fixed_mul(y, s);
      end
    end
    r.screen_x   = fit_coord(sx, sat);
    r.screen_y   = fit_coord(sy, sat);
    r.depth_out  = fit_coord(d, sat);
    r.zero_depth = 1'b0;
    r.saturated  = sat;
    return r;
  endfunction

  assign pending = screen_q.size();

  always @(posedge clk) begin
    vsp_out_t want;
    if (!rst_n) begin
      proj_cfg.mode        <= 1'b1;
      proj_cfg.focal       <= '0;
      proj_cfg.oscale      <= OSW'(1 << FRAC);
      proj_cfg.aspect      <= ASPW'(1 << FRAC);
      proj_cfg.half_width  <= '0;
      proj_cfg.half_height <= '0;
      screen_q.delete();
      fail_count   <= 0;
      results_seen <= 0;
      mismatches   = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MODE:    proj_cfg.mode        <= cfg_wdata[0];
          CFG_FOCAL:   proj_cfg.focal       <= cfg_wdata[FOCW-1:0];
          CFG_OSCALE:  proj_cfg.oscale      <= cfg_wdata[OSW-1:0];
          CFG_ASPECT:  proj_cfg.aspect      <= cfg_wdata[ASPW-1:0];
          CFG_HWIDTH:  proj_cfg.half_width  <= cfg_wdata[HALFW-1:0];
          CFG_HHEIGHT: proj_cfg.half_height <= cfg_wdata[HALFW-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) screen_q.push_back(project_vertex(proj_cfg, in_data));
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (screen_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with no request pending: %p", out_data);
        end else begin
          want = screen_q.pop_front();
          if (out_data !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected x=%h y=%h d=%h zd=%b sat=%b, got x=%h y=%h d=%h zd=%b sat=%b",
                       want.screen_x, want.screen_y, want.depth_out, want.zero_depth,
                       want.saturated, out_data.screen_x, out_data.screen_y,
                       out_data.depth_out, out_data.zero_depth, out_data.saturated);
          end
        end
        fail_count <= mismatches;
      end
    end
  end
endmodule

>>> bench/tb_top.sv
// tb_top: stimulus and verdict for vertex_screen_projection; the checker
// beside the block predicts and compares. Depends on vsp_pkg, vsp_checker.
`timescale 1ns / 100ps

module tb_top;
  import vsp_pkg::*;

  localparam int LATENCY  = 58;
  localparam int IDLE_LIM = 5000;
  localparam int HOLD_LEN = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  vsp_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  vsp_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count, pending, results_seen;
  int sent;
  int hold_asked, hold_done;
  int idle_cycles;

  vertex_screen_projection i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  vsp_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: give up when no request moves on any port for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIM) begin
      $display("watchdog expired, %0d results outstanding", pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: change the stall density now and then; serve each long
  // hold-off the stimulus asks for by counting it out here.
  initial begin
    int density, span, hold_left;
    out_stall = 1'b0;
    density   = 0;
    span      = 0;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_done < hold_asked) begin
        hold_left = HOLD_LEN;
        hold_done++;
      end
      if (span == 0) begin
        density = $urandom_range(0, 3) * 25;  // 0, 25, 50 or 75 percent
        span    = $urandom_range(20, 150);
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < density);
      end
    end
  end

  // Write one register; leaves the enable high for the caller to drop
  // after the last write of a group.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Hold the sender until the pipeline has drained before touching registers.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // Offer one vertex and advance until it is taken.
  task automatic offer_vertex(input vsp_in_t v);
    in_valid <= 1'b1;
    in_data  <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Burst/gap pacing between requests.
  task automatic pace_sender();
    int gap;
    if ($urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'(signed'($urandom_range(0, 2000)) - 1000);
      3, 4:    return 32'(signed'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic vsp_in_t pick_vertex();
    vsp_in_t v;
    v.vx = pick_coord();
    v.vy = ($urandom_range(0, 15) == 0) ? 32'h0 : pick_coord();
    v.vz = pick_coord();
    return v;
  endfunction

  task automatic send_batch(input int n);
    for (int i = 0; i < n; i++) begin
      offer_vertex(pick_vertex());
      pace_sender();
    end
  endtask

  task automatic random_config(input logic persp);
    write_reg(CFG_MODE, (($urandom_range(0, 1) ? $urandom : 32'h0) & 32'hFFFF_FFFE)
                        | 32'(persp));
    write_reg(CFG_FOCAL, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0100_0000));
    write_reg(CFG_OSCALE, $urandom_range(0, 1) ? $urandom
                          : 32'(signed'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000));
    write_reg(CFG_ASPECT, $urandom_range(0, 2) == 0 ? 32'h0001_0000
                          : ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0003_0000)));
    write_reg(CFG_HWIDTH, $urandom);
    write_reg(CFG_HHEIGHT, $urandom);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int phase;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_wdata  = '0;
    sent       = 0;
    hold_asked = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: perspective with zero focal length, including zero depth.
    offer_vertex('{vx: 32'h0001_0000, vy: 32'h0000_0000, vz: 32'h0001_0000});
    offer_vertex('{vx: 32'h7FFF_FFFF, vy: 32'h0000_0001, vz: 32'h8000_0000});
    offer_vertex('{vx: 32'h8000_0000, vy: 32'hFFFF_FFFF, vz: 32'h7FFF_FFFF});
    drain_pipe();

    // Perspective, largest focal length and screen center.
    write_reg(CFG_FOCAL, 32'hFFFF_FFFF);
    write_reg(CFG_HWIDTH, 32'h1000_0000);
    write_reg(CFG_HHEIGHT, 32'h1000_0000);
    write_reg(3'd6, 32'h0);  // out-of-list index: must be ignored
    write_reg(3'd7, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;
    offer_vertex('{vx: 32'h0000_0000, vy: 32'h0000_0000, vz: 32'h0000_0000});
    offer_vertex('{vx: 32'h0001_0000, vy: 32'h0001_0000, vz: 32'hFFFF_0000});
    offer_vertex('{vx: 32'h7FFF_FFFF, vy: 32'h8000_0000, vz: 32'h7FFF_FFFF});
    offer_vertex('{vx: 32'h8000_0000, vy: 32'h7FFF_FFFF, vz: 32'h8000_0000});
    offer_vertex('{vx: 32'h0000_0010, vy: 32'h0100_0000, vz: 32'h0000_0010});
    drain_pipe();

    // Orthographic, square aspect, most negative scale.
    write_reg(CFG_MODE, 32'hFFFF_FFFE);
    write_reg(CFG_OSCALE, 32'h8000_0000);
    write_reg(CFG_ASPECT, 32'h8001_0000);  // upper bit dropped: exactly 1.0
    write_reg(CFG_HWIDTH, 32'h0);
    cfg_we <= 1'b0;
    offer_vertex('{vx: 32'h7FFF_FFFF, vy: 32'h0000_0000, vz: 32'h8000_0000});
    offer_vertex('{vx: 32'h8000_0000, vy: 32'h8000_0000, vz: 32'h7FFF_FFFF});
    offer_vertex('{vx: 32'hFFFF_FFFF, vy: 32'h0000_0001, vz: 32'h0000_0001});
    offer_vertex('{vx: 32'h0000_0000, vy: 32'hFFFF_FFFF, vz: 32'h0000_0000});
    drain_pipe();

    // Orthographic, non-square aspect at its extremes and largest scale.
    write_reg(CFG_OSCALE, 32'h7FFF_FFFF);
    write_reg(CFG_ASPECT, 32'h7FFF_FFFF);
    cfg_we <= 1'b0;
    offer_vertex('{vx: 32'h0001_0000, vy: 32'h0001_0000, vz: 32'hFFFF_FFFF});
    offer_vertex('{vx: 32'h8000_0000, vy: 32'h7FFF_FFFF, vz: 32'h8000_0000});
    drain_pipe();
    write_reg(CFG_ASPECT, 32'h0);
    write_reg(CFG_OSCALE, 32'hFFFF_0000);
    cfg_we <= 1'b0;
    offer_vertex('{vx: 32'h0003_0000, vy: 32'h8000_0000, vz: 32'h7FFF_FFFF});
    offer_vertex('{vx: 32'hFFFF_FFFF, vy: 32'hFFFF_FFFF, vz: 32'hFFFF_FFFF});
    drain_pipe();

    // Random phases, alternating modes, one with a long receiver hold-off.
    for (phase = 0; phase < 6; phase++) begin
      random_config(phase[0]);
      if (phase == 2) begin
        hold_asked++;  // receiver freezes while the sender keeps offering
        send_batch(40);
      end
      send_batch(70);
      drain_pipe();
    end

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d vertices and %0d results over both projection modes,", sent,
             results_seen);
    $display("square and stretched aspect, zero depth, clamping and a long output hold-off");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
